### hw/rtl/wrw_pkg.sv
// ----------------------------------------------------------------------------
// Water ripple warp package
// Shared types, codes and the quarter-wave sine table function.
// ----------------------------------------------------------------------------
package wrw_pkg;

    localparam int CALC_BITS = 40;

    typedef logic signed [CALC_BITS-1:0] t_calc;

    typedef enum logic [1:0] {
        KIND_WARP    = 2'd0,
        KIND_COPY    = 2'd1,
        KIND_OUTSIDE = 2'd2
    } t_copy_kind;

    typedef enum logic [2:0] {
        CFG_AMPLITUDES  = 3'd0,
        CFG_FREQUENCIES = 3'd1,
        CFG_PHASES      = 3'd2,
        CFG_ROI         = 3'd3,
        CFG_SIZES       = 3'd4,
        CFG_LAYOUT      = 3'd5,
        CFG_BASE        = 3'd6
    } t_cfg_index;

    // Long division used only while the table constants are elaborated.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int              b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Rounded 16384*sin(pi/2*k/q) with q = 2^(tbits-2), from a Q30 series.
    function automatic logic [14:0] quarter_sine(input int k, input int tbits);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint unsigned sum;
        int              i;
        a    = (64'd1686629713 * longint'(k)) >> (tbits - 2);
        a2   = (a * a) >> 30;
        term = a;
        sum  = a;
        for (i = 1; i <= 10; i++) begin
            term = div_u64((term * a2) >> 30, 64'((2 * i) * (2 * i + 1)));
            if (i[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return 15'((sum * 64'd16384 + (64'd1 << 29)) >> 30);
    endfunction

endpackage

### hw/rtl/wrw_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel coordinate channel
// Valid/ready channel that carries one destination pixel per transfer.
// ----------------------------------------------------------------------------
interface wrw_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### hw/rtl/wrw_res_if.sv
// ----------------------------------------------------------------------------
// Address result channel
// Valid/ready channel that carries one channel address pair per transfer.
// ----------------------------------------------------------------------------
interface wrw_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        write_enable;
    logic [1:0]  copy_kind;
    logic        last_channel;

    modport source (
        output valid, output src_addr, output dst_addr, output write_enable,
        output copy_kind, output last_channel, input ready
    );
    modport sink (
        input valid, input src_addr, input dst_addr, input write_enable,
        input copy_kind, input last_channel, output ready
    );
endinterface

### hw/rtl/water_ripple_warp_address_gen.sv
// ----------------------------------------------------------------------------
// Water ripple warp address generator
// Maps each destination pixel to per-channel source and destination element
// addresses for a sinusoidal ripple warp inside a region of interest.
// ----------------------------------------------------------------------------
// A pixel enters in any cycle the seven-stage pipeline can advance and
// yields one result per channel, one result per cycle while the receiver
// is ready, last flagged. The output serializer sets the sustained rate:
// it takes the next pixel only as the last channel result is accepted.
// Settings are registered; plane size, limit and increments are derived in registers.
module water_ripple_warp_address_gen #(
    parameter int COORD_BITS      = 16,
    parameter int ADDR_BITS       = 32,
    parameter int MAX_CHANNELS    = 4,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    wrw_pix_if.sink     i_pix,
    wrw_res_if.source   o_res
);

    localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [1:0]  CH_MAX_M1 = 2'(MAX_CHANNELS - 1);

    logic [31:0] r_amp, r_freq, r_phase, r_base;
    logic [63:0] r_roi, r_sizes;
    logic [3:0]  r_layout;

    logic [15:0] w_sw, w_sh;
    logic [1:0]  w_ch_m1;
    logic [2:0]  w_ch, w_in_mul, w_out_mul;

    logic [31:0]         r_plane;
    wrw_pkg::t_calc      r_limit, r_src_inc, r_dst_inc;

    logic                w_adv, w_load, w_last;
    logic [15:0]         w_x, w_y;
    wrw_pkg::t_copy_kind w_kind;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    logic [15:0]         r1_x, r1_y, r1_ang_x, r1_ang_y;
    logic [31:0]         r1_yw;
    wrw_pkg::t_copy_kind r1_kind;

    logic [15:0]         r2_x, r2_y;
    logic [32:0]         r2_dlin;
    wrw_pkg::t_copy_kind r2_kind;
    logic signed [15:0]  w_sin_x, w_sin_y;

    logic [15:0]         r3_x, r3_y;
    logic signed [31:0]  r3_px, r3_py;
    wrw_pkg::t_calc      r3_dst0;
    wrw_pkg::t_copy_kind r3_kind;

    wrw_pkg::t_calc      w_tx, w_ty, w_sx, w_sy;
    logic signed [17:0]  r4_sx, r4_sy;
    wrw_pkg::t_calc      r4_dst0;
    wrw_pkg::t_copy_kind r4_kind;

    logic signed [17:0]  r5_sx;
    wrw_pkg::t_calc      r5_syw, r5_dst0;
    wrw_pkg::t_copy_kind r5_kind;

    wrw_pkg::t_calc      r6_lin, r6_dst0;
    wrw_pkg::t_copy_kind r6_kind;

    wrw_pkg::t_calc      r7_src0, r7_dst0;
    wrw_pkg::t_copy_kind r7_kind;

    logic                r_ov;
    logic [1:0]          r_chan;
    wrw_pkg::t_calc      r_s, r_d, r_sinc;
    wrw_pkg::t_copy_kind r_kind;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp    <= '0;
            r_freq   <= '0;
            r_phase  <= '0;
            r_roi    <= '0;
            r_sizes  <= '0;
            r_layout <= '0;
            r_base   <= '0;
        end else if (i_cfg_we) begin
            case (wrw_pkg::t_cfg_index'(i_cfg_index))
                wrw_pkg::CFG_AMPLITUDES:  r_amp    <= i_cfg_data[31:0];
                wrw_pkg::CFG_FREQUENCIES: r_freq   <= i_cfg_data[31:0];
                wrw_pkg::CFG_PHASES:      r_phase  <= i_cfg_data[31:0];
                wrw_pkg::CFG_ROI:         r_roi    <= i_cfg_data;
                wrw_pkg::CFG_SIZES:       r_sizes  <= i_cfg_data;
                wrw_pkg::CFG_LAYOUT:      r_layout <= i_cfg_data[3:0];
                wrw_pkg::CFG_BASE:        r_base   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign w_sw      = r_sizes[31:16];
    assign w_sh      = r_sizes[15:0];
    assign w_ch_m1   = (r_layout[1:0] > CH_MAX_M1) ? CH_MAX_M1 : r_layout[1:0];
    assign w_ch      = {1'b0, w_ch_m1} + 3'd1;
    assign w_in_mul  = r_layout[2] ? w_ch : 3'd1;
    assign w_out_mul = r_layout[3] ? w_ch : 3'd1;

    always_ff @(posedge i_clk) begin
        r_plane   <= w_sw * w_sh;
        r_limit   <= wrw_pkg::t_calc'(r_base)
                     + wrw_pkg::t_calc'(r_plane) * $signed({1'b0, w_ch});
        r_src_inc <= r_layout[2] ? wrw_pkg::t_calc'(1) : wrw_pkg::t_calc'(r_plane);
        r_dst_inc <= r_layout[3] ? wrw_pkg::t_calc'(1) : wrw_pkg::t_calc'(r_plane);
    end

    assign w_last = (r_chan == w_ch_m1);
    assign w_load = r_v7 && (!r_ov || (o_res.ready && w_last));
    assign w_adv  = !r_v7 || w_load;
    assign i_pix.ready = w_adv;

    assign w_x = 16'(i_pix.pixel_x[COORD_BITS-1:0]);
    assign w_y = 16'(i_pix.pixel_y[COORD_BITS-1:0]);

    always_comb begin
        if (w_x >= r_roi[63:48] && w_x <= r_roi[47:32] &&
            w_y >= r_roi[31:16] && w_y <= r_roi[15:0]) begin
            w_kind = wrw_pkg::KIND_WARP;
        end else if (w_x < r_sizes[63:48] && w_y < r_sizes[47:32]) begin
            w_kind = wrw_pkg::KIND_COPY;
        end else begin
            w_kind = wrw_pkg::KIND_OUTSIDE;
        end
    end

    wrw_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_sine_x (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (r1_ang_x),
        .o_sine  (w_sin_x)
    );

    wrw_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_sine_y (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (r1_ang_y),
        .o_sine  (w_sin_y)
    );

    assign w_tx = (wrw_pkg::t_calc'(r3_x) <<< 22) + wrw_pkg::t_calc'(r3_px);
    assign w_ty = (wrw_pkg::t_calc'(r3_y) <<< 22) + wrw_pkg::t_calc'(r3_py);
    assign w_sx = (w_tx + (w_tx[wrw_pkg::CALC_BITS-1] ?
                  wrw_pkg::t_calc'(22'h3F_FFFF) : wrw_pkg::t_calc'(0))) >>> 22;
    assign w_sy = (w_ty + (w_ty[wrw_pkg::CALC_BITS-1] ?
                  wrw_pkg::t_calc'(22'h3F_FFFF) : wrw_pkg::t_calc'(0))) >>> 22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_pix.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_x     <= w_x;
            r1_y     <= w_y;
            r1_ang_x <= 16'(r_freq[31:16] * w_y) + r_phase[31:16];
            r1_ang_y <= 16'(r_freq[15:0] * w_x) + r_phase[15:0] + 16'h4000;
            r1_yw    <= w_y * w_sw;
            r1_kind  <= w_kind;

            r2_x     <= r1_x;
            r2_y     <= r1_y;
            r2_dlin  <= {17'd0, r1_x} + {1'b0, r1_yw};
            r2_kind  <= r1_kind;

            r3_x     <= r2_x;
            r3_y     <= r2_y;
            r3_px    <= $signed(r_amp[31:16]) * w_sin_x;
            r3_py    <= $signed(r_amp[15:0]) * w_sin_y;
            r3_dst0  <= wrw_pkg::t_calc'(r_base)
                        + wrw_pkg::t_calc'(r2_dlin) * $signed({1'b0, w_out_mul});
            r3_kind  <= r2_kind;

            r4_sx    <= 18'(w_sx);
            r4_sy    <= 18'(w_sy);
            r4_dst0  <= r3_dst0;
            r4_kind  <= r3_kind;

            r5_sx    <= r4_sx;
            r5_syw   <= wrw_pkg::t_calc'(r4_sy) * $signed({1'b0, w_sw});
            r5_dst0  <= r4_dst0;
            r5_kind  <= r4_kind;

            r6_lin   <= wrw_pkg::t_calc'(r5_sx) + r5_syw;
            r6_dst0  <= r5_dst0;
            r6_kind  <= r5_kind;

            r7_src0  <= wrw_pkg::t_calc'(r_base) + r6_lin * $signed({1'b0, w_in_mul});
            r7_dst0  <= r6_dst0;
            r7_kind  <= r6_kind;
        end
    end

    // Output serializer: one channel result per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (r_ov && o_res.ready && w_last) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_chan <= '0;
            r_kind <= r7_kind;
            r_d    <= r7_dst0;
            case (r7_kind)
                wrw_pkg::KIND_WARP: begin
                    r_s    <= r7_src0;
                    r_sinc <= r_src_inc;
                end
                wrw_pkg::KIND_COPY: begin
                    r_s    <= r7_dst0;
                    r_sinc <= r_dst_inc;
                end
                default: begin
                    r_s    <= '0;
                    r_sinc <= '0;
                end
            endcase
        end else if (r_ov && o_res.ready) begin
            r_chan <= r_chan + 2'd1;
            r_s    <= r_s + r_sinc;
            r_d    <= r_d + r_dst_inc;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.src_addr     = 32'(r_s) & AMASK;
    assign o_res.dst_addr     = 32'(r_d) & AMASK;
    assign o_res.copy_kind    = r_kind;
    assign o_res.last_channel = w_last;
    assign o_res.write_enable = (r_kind == wrw_pkg::KIND_WARP) ?
                                (!r_s[wrw_pkg::CALC_BITS-1] && (r_s < r_limit)) :
                                (r_kind == wrw_pkg::KIND_COPY);

endmodule

### hw/rtl/wrw_sine.sv
// ----------------------------------------------------------------------------
// Ripple sine lookup
// Registered Q1.14 sine of a Q0.16 angle from a quarter-wave table.
// ----------------------------------------------------------------------------
module wrw_sine #(
    parameter int TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_angle,
    output logic signed [15:0] o_sine
);

    localparam int QUARTER = 1 << (TABLE_BITS - 2);

    logic [14:0]           w_tab [QUARTER+1];
    logic [TABLE_BITS-1:0] w_p;
    logic [1:0]            w_quad;
    logic [TABLE_BITS-2:0] w_r;
    logic [TABLE_BITS-2:0] w_k;
    logic signed [15:0]    w_val;
    logic signed [15:0]    r_sine;

    for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
        localparam logic [14:0] ENTRY = wrw_pkg::quarter_sine(k, TABLE_BITS);
        assign w_tab[k] = ENTRY;
    end

    assign w_p    = i_angle[15 -: TABLE_BITS];
    assign w_quad = w_p[TABLE_BITS-1 -: 2];
    assign w_r    = {1'b0, w_p[TABLE_BITS-3:0]};
    assign w_k    = w_quad[0] ? ((TABLE_BITS-1)'(QUARTER) - w_r) : w_r;
    assign w_val  = $signed({1'b0, w_tab[w_k]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine <= w_quad[1] ? -w_val : w_val;
        end
    end

    assign o_sine = r_sine;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Water ripple warp address generator testbench
// Drives destination pixels through several register settings, predicts the
// per-channel source and destination addresses, and checks every result
// transfer in order against the prediction, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic [31:0]         src_addr;
        logic [31:0]         dst_addr;
        logic                write_enable;
        wrw_pkg::t_copy_kind copy_kind;
        logic                last_channel;
    } t_addr_pair;

    class warp_scoreboard;
        logic [31:0] amp, freq, phase, base;
        logic [63:0] roi, sizes;
        logic [3:0]  layout;
        t_addr_pair  pending[$];
        int          errors;

        function new();
            amp = 0; freq = 0; phase = 0; base = 0; roi = 0; sizes = 0; layout = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                wrw_pkg::CFG_AMPLITUDES:  amp = v[31:0];
                wrw_pkg::CFG_FREQUENCIES: freq = v[31:0];
                wrw_pkg::CFG_PHASES:      phase = v[31:0];
                wrw_pkg::CFG_ROI:         roi = v;
                wrw_pkg::CFG_SIZES:       sizes = v;
                wrw_pkg::CFG_LAYOUT:      layout = v[3:0];
                wrw_pkg::CFG_BASE:        base = v[31:0];
                default: ;
            endcase
        endfunction

        function longint quarter_wave(longint unsigned k);
            longint unsigned ang, sq, term, acc;
            ang = (64'd1686629713 * k) >> 8;
            sq = (ang * ang) >> 30;
            term = ang;
            acc = ang;
            for (int i = 1; i <= 10; i++) begin
                term = ((term * sq) >> 30) / longint'((2 * i) * (2 * i + 1));
                if (i % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            return longint'((acc * 64'd16384 + (64'd1 << 29)) >> 30);
        endfunction

        function longint ripple_sine(logic [15:0] angle);
            logic [9:0] p;
            longint v;
            p = angle[15:6];
            v = quarter_wave(p[8] ? 256 - p[7:0] : p[7:0]);
            return p[9] ? -v : v;
        endfunction

        function longint displace(longint c, logic [15:0] a, logic [15:0] angle);
            longint t;
            t = c * 4194304 + longint'($signed(a)) * ripple_sine(angle);
            return t / 4194304;
        endfunction

        function void note_pixel(logic [15:0] x, logic [15:0] y);
            longint sw, plane, ch, in_mul, out_mul, src_inc, dst_inc, lim, dst0, src0;
            longint d, s;
            t_addr_pair r;
            wrw_pkg::t_copy_kind k;
            logic [15:0] ang_x, ang_y;
            sw = sizes[31:16];
            plane = sw * longint'(sizes[15:0]);
            ch = longint'(layout[1:0]) + 1;
            in_mul = layout[2] ? ch : 1;
            out_mul = layout[3] ? ch : 1;
            src_inc = layout[2] ? 1 : plane;
            dst_inc = layout[3] ? 1 : plane;
            lim = longint'(base) + plane * ch;
            dst0 = longint'(base) + (longint'(x) + longint'(y) * sw) * out_mul;
            src0 = 0;
            if (x >= roi[63:48] && x <= roi[47:32] && y >= roi[31:16] && y <= roi[15:0]) begin
                ang_x = freq[31:16] * y + phase[31:16];
                ang_y = freq[15:0] * x + phase[15:0] + 16'h4000;
                src0 = longint'(base) + (displace(x, amp[31:16], ang_x)
                       + displace(y, amp[15:0], ang_y) * sw) * in_mul;
                k = wrw_pkg::KIND_WARP;
            end else if (x < sizes[63:48] && y < sizes[47:32]) begin
                k = wrw_pkg::KIND_COPY;
            end else begin
                k = wrw_pkg::KIND_OUTSIDE;
            end
            for (longint c = 0; c < ch; c++) begin
                d = dst0 + c * dst_inc;
                case (k)
                    wrw_pkg::KIND_WARP: begin
                        s = src0 + c * src_inc;
                        r.write_enable = (s >= 0 && s < lim);
                    end
                    wrw_pkg::KIND_COPY: begin
                        s = d;
                        r.write_enable = 1'b1;
                    end
                    default: begin
                        s = 0;
                        r.write_enable = 1'b0;
                    end
                endcase
                r.src_addr = s[31:0];
                r.dst_addr = d[31:0];
                r.copy_kind = k;
                r.last_channel = (c + 1 == ch);
                pending.push_back(r);
            end
        endfunction

        function void check_result(t_addr_pair got);
            t_addr_pair e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer src=%h dst=%h", got.src_addr, got.dst_addr);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.src_addr !== e.src_addr) begin
                $error("src_addr exp %h got %h", e.src_addr, got.src_addr);
                errors++;
            end
            if (got.dst_addr !== e.dst_addr) begin
                $error("dst_addr exp %h got %h", e.dst_addr, got.dst_addr);
                errors++;
            end
            if (got.write_enable !== e.write_enable) begin
                $error("write_enable exp %b got %b", e.write_enable, got.write_enable);
                errors++;
            end
            if (got.copy_kind !== e.copy_kind) begin
                $error("copy_kind exp %0d got %0d", e.copy_kind, got.copy_kind);
                errors++;
            end
            if (got.last_channel !== e.last_channel) begin
                $error("last_channel exp %b got %b", e.last_channel, got.last_channel);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    int          cycle_count;
    int          hold_off_req;
    int          burst_left;
    warp_scoreboard sb;

    wrw_pix_if pix ();
    wrw_res_if res ();

    water_ripple_warp_address_gen u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix.sink),
        .o_res       (res.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        pix.valid = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        res.ready = 1'b0;
        cycle_count = 0;
        hold_off_req = 0;
        burst_left = 0;
        sb = new();
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** water_ripple_warp_address_gen: FAILED **");
            $finish;
        end
    end

    // Receiver: checks each transfer and stalls on its own pattern.
    int stall_left;
    int stall_mode;
    always @(posedge i_clk) begin
        t_addr_pair got;
        if (!i_rst_n) begin
            stall_left <= 0;
            stall_mode <= 0;
        end else begin
            if (res.valid && res.ready) begin
                got.src_addr = res.src_addr;
                got.dst_addr = res.dst_addr;
                got.write_enable = res.write_enable;
                got.copy_kind = wrw_pkg::t_copy_kind'(res.copy_kind);
                got.last_channel = res.last_channel;
                sb.check_result(got);
            end
            if (hold_off_req > 0) begin
                stall_left <= hold_off_req;
                hold_off_req = 0;
                res.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                res.ready <= 1'b0;
            end else begin
                if (cycle_count % 64 == 0) begin
                    stall_mode <= $urandom_range(0, 2);
                end
                case (stall_mode)
                    0: res.ready <= 1'b1;
                    1: res.ready <= ($urandom_range(0, 1) == 1);
                    default: res.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [63:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [15:0] x, logic [15:0] y);
        int gap;
        pix.valid <= 1'b1;
        pix.pixel_x <= x;
        pix.pixel_y <= y;
        do @(posedge i_clk); while (!pix.ready);
        sb.note_pixel(x, y);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain;
        pix.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] a, logic [31:0] f, logic [31:0] p,
                           logic [63:0] roi, logic [63:0] sz, logic [3:0] lay,
                           logic [31:0] b);
        write_cfg(wrw_pkg::CFG_AMPLITUDES, {32'h0, a});
        write_cfg(wrw_pkg::CFG_FREQUENCIES, {32'h0, f});
        write_cfg(wrw_pkg::CFG_PHASES, {32'h0, p});
        write_cfg(wrw_pkg::CFG_ROI, roi);
        write_cfg(wrw_pkg::CFG_SIZES, sz);
        write_cfg(wrw_pkg::CFG_LAYOUT, {60'h0, lay});
        write_cfg(wrw_pkg::CFG_BASE, {32'h0, b});
        repeat (3) @(posedge i_clk);
    endtask

    task automatic random_phase(int count, bit wide);
        logic [15:0] w, h, sw, sh, xb, xe, yb, ye;
        w = wide ? 16'($urandom) : 16'($urandom_range(1, 40));
        h = wide ? 16'($urandom) : 16'($urandom_range(1, 40));
        sw = w + 16'($urandom_range(0, 4));
        sh = h + 16'($urandom_range(0, 4));
        xb = 16'($urandom_range(0, w));
        xe = $urandom_range(0, 3) == 0 ? xb - 16'd1 : xb + 16'($urandom_range(0, 20));
        yb = 16'($urandom_range(0, h));
        ye = yb + 16'($urandom_range(0, 20));
        set_all($urandom, $urandom, $urandom, {xb, xe, yb, ye}, {w, h, sw, sh},
                4'($urandom), $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_pixel(16'($urandom), 16'($urandom));
            end else begin
                send_pixel(16'($urandom_range(0, w + 2)), 16'($urandom_range(0, h + 2)));
            end
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at reset: single-pixel region at the origin, zero-size image.
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        drain();

        // Full-range region, extreme amplitudes, packed and planar layouts.
        set_all(32'h7FFF_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0000_FFFF_0000_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        write_cfg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'd0);
        send_pixel(16'd0, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'h7FFF);
        drain();
        set_all(32'h8000_7FFF, 32'h0001_0100, 32'h4000_C000, 64'h0002_0005_0003_0006,
                64'h0008_0008_000A_0009, 4'h3, 32'h0);
        send_pixel(16'd2, 16'd3);
        send_pixel(16'd5, 16'd6);
        send_pixel(16'd1, 16'd3);
        send_pixel(16'd7, 16'd7);
        send_pixel(16'd8, 16'd0);
        send_pixel(16'd0, 16'd8);
        send_pixel(16'd6, 16'd6);
        drain();
        set_all(32'h0000_0000, 32'h0, 32'h0, 64'h0004_0002_0000_0003,
                64'h0004_0004_0004_0004, 4'h4, 32'h10);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'd3, 16'd3);
        send_pixel(16'd4, 16'd1);
        drain();

        // Long receiver hold-off while pixels keep coming.
        set_all(32'h0300_FD00, 32'h0800_0400, 32'h0, 64'h0000_0010_0000_0010,
                64'h0014_0014_0014_0014, 4'h3, 32'h0);
        hold_off_req = 300;
        for (int i = 0; i < 30; i++) begin
            send_pixel(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)));
        end
        drain();

        for (int ph = 0; ph < 14; ph++) begin
            random_phase(8, ph % 5 == 4);
        end

        drain();
        if (sb.errors == 0) begin
            $display("** water_ripple_warp_address_gen: PASSED **");
        end else begin
            $display("** water_ripple_warp_address_gen: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/wrw_pkg.sv
hw/rtl/wrw_pix_if.sv
hw/rtl/wrw_res_if.sv
hw/rtl/wrw_sine.sv
hw/rtl/water_ripple_warp_address_gen.sv
tb/tb_top.sv
